FILE: rtl/core/wmmp_pkg.sv
// Shared types, constants and helpers of the waveform min/max plotter.
package wmmp_pkg;

   localparam int COORD_BITS = 12;
   localparam int CoordW     = COORD_BITS + 1;
   localparam int SampleW    = 16;
   localparam int ZoomW      = 16;
   localparam int CountW     = 16;
   localparam int ExtW       = 13;
   localparam int ColorW     = 3;
   localparam int RgbW       = 16;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 16;

   // Column offset is below the plot width, so the quotient fits the width field.
   localparam int QuoW       = ExtW;
   localparam int DivCntW    = $clog2(QuoW + 1);

   localparam int MulAW      = 29;
   localparam int MulBW      = 17;
   localparam int ProdW      = MulAW + MulBW;
   localparam int PW         = SampleW + ZoomW + 1;
   localparam int OneShift   = 27;
   localparam int RowShift   = OneShift + 1;

   localparam logic KIND_LINE = 1'b0;
   localparam logic KIND_SPAN = 1'b1;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LEFT,
      CSR_TOP,
      CSR_WIDTH,
      CSR_HEIGHT,
      CSR_ZOOM,
      CSR_COUNT,
      CSR_COLOR
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARITH,
      ST_DECIDE,
      ST_LINE,
      ST_JOIN,
      ST_SPAN,
      ST_FINISH
   } top_state_type;

   typedef enum logic [2:0] {
      A_IDLE,
      A_MUL_P,
      A_CLIP,
      A_MUL_H,
      A_MUL_K,
      A_LOAD,
      A_DIV,
      A_DONE
   } arith_state_type;

   typedef struct packed {
      logic                      start;
      logic signed [SampleW-1:0] sample;
      logic [CountW-1:0]         k;
      logic [ZoomW-1:0]          zoom;
      logic [ExtW-1:0]           height;
      logic [COORD_BITS-1:0]     top;
      logic [ExtW-1:0]           width;
      logic [CountW-1:0]         count;
   } arith_req_type;

   typedef struct packed {
      logic              done;
      logic [CoordW-1:0] row;
      logic [QuoW-1:0]   off;
   } arith_rsp_type;

   function automatic logic [RgbW-1:0] palette_lookup(input logic [ColorW-1:0] idx);
      logic [RgbW-1:0] c;
      unique case (idx)
         3'd0: c = 16'h07E0;
         3'd1: c = 16'hFFE0;
         3'd2: c = 16'h001F;
         3'd3: c = 16'hF800;
         3'd4: c = 16'h07FF;
         3'd5: c = 16'hFC00;
         3'd6: c = 16'hF81F;
         default: c = 16'hFFFF;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/core/wmmp_req_if.sv
// Sample channel of the waveform min/max plotter.
interface wmmp_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [wmmp_pkg::SampleW-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

FILE: rtl/core/wmmp_rsp_if.sv
// Draw command channel of the waveform min/max plotter.
interface wmmp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [wmmp_pkg::CoordW-1:0] x_start;
   logic [wmmp_pkg::CoordW-1:0] y_start;
   logic [wmmp_pkg::CoordW-1:0] x_end;
   logic [wmmp_pkg::CoordW-1:0] y_end;
   logic [wmmp_pkg::RgbW-1:0]   rgb565;
   logic                        last;

   modport source (output valid, output kind, output x_start, output y_start,
                   output x_end, output y_end, output rgb565, output last, input ready);
   modport sink (input valid, input kind, input x_start, input y_start,
                 input x_end, input y_end, input rgb565, input last, output ready);
endinterface

FILE: rtl/core/wmmp_arith.sv
// Row and column-offset unit: one shared multiplier and a restoring divider.
module wmmp_arith (
   input  logic                    clock,
   input  logic                    reset,
   input  wmmp_pkg::arith_req_type arith_req,
   output wmmp_pkg::arith_rsp_type arith_rsp
);

   localparam logic signed [wmmp_pkg::PW-1:0] OneQ27 =
      wmmp_pkg::PW'(1) << wmmp_pkg::OneShift;
   localparam logic signed [wmmp_pkg::PW-1:0] NegOneQ27 = -OneQ27;

   wmmp_pkg::arith_state_type state_ff, state_in;

   logic signed [wmmp_pkg::ProdW-1:0]   prod_ff, prod_in;
   logic                                prod_en;
   logic [wmmp_pkg::OneShift:0]         diff_ff, diff_in;
   logic                                clip_hi_ff, clip_hi_in;
   logic                                clip_lo_ff, clip_lo_in;
   logic [wmmp_pkg::CoordW-1:0]         row_ff, row_in;
   logic [wmmp_pkg::CountW-1:0]         rem_ff, rem_in;
   logic [wmmp_pkg::QuoW-1:0]           quo_ff, quo_in;
   logic [wmmp_pkg::DivCntW-1:0]        cnt_ff, cnt_in;

   logic signed [wmmp_pkg::MulAW-1:0]   mul_a;
   logic signed [wmmp_pkg::MulBW-1:0]   mul_b;
   logic signed [wmmp_pkg::PW-1:0]      p;
   logic signed [wmmp_pkg::PW-1:0]      diff_full;
   logic [wmmp_pkg::ExtW-1:0]           h_eff;
   logic [wmmp_pkg::ExtW-1:0]           q;
   logic [wmmp_pkg::ExtW-1:0]           row_sel;
   logic [wmmp_pkg::CountW:0]           div_t;
   logic [wmmp_pkg::CountW:0]           div_sub;
   logic                                div_ge;
   logic                                done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wmmp_pkg::A_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_en) begin
         prod_ff <= prod_in;
      end
      diff_ff    <= diff_in;
      clip_hi_ff <= clip_hi_in;
      clip_lo_ff <= clip_lo_in;
      row_ff     <= row_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
   end

   always_comb begin
      state_in   = state_ff;
      diff_in    = diff_ff;
      clip_hi_in = clip_hi_ff;
      clip_lo_in = clip_lo_ff;
      row_in     = row_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      mul_a      = '0;
      mul_b      = '0;
      prod_en    = 1'b0;
      done       = 1'b0;

      h_eff     = (arith_req.height == '0) ? wmmp_pkg::ExtW'(1) : arith_req.height;
      p         = prod_ff[wmmp_pkg::PW-1:0];
      diff_full = OneQ27 - p;
      q         = prod_ff[wmmp_pkg::RowShift+wmmp_pkg::ExtW-1:wmmp_pkg::RowShift];
      div_t     = {rem_ff, quo_ff[wmmp_pkg::QuoW-1]};
      div_ge    = div_t >= (wmmp_pkg::CountW+1)'(arith_req.count);
      div_sub   = div_t - (wmmp_pkg::CountW+1)'(arith_req.count);

      priority if (clip_hi_ff) begin
         row_sel = '0;
      end else if (clip_lo_ff) begin
         row_sel = h_eff - wmmp_pkg::ExtW'(1);
      end else begin
         row_sel = q;
      end

      unique case (state_ff)
         wmmp_pkg::A_IDLE: begin
            if (arith_req.start) begin
               state_in = wmmp_pkg::A_MUL_P;
            end
         end
         wmmp_pkg::A_MUL_P: begin
            mul_a    = wmmp_pkg::MulAW'(arith_req.sample);
            mul_b    = signed'(wmmp_pkg::MulBW'(arith_req.zoom));
            prod_en  = 1'b1;
            state_in = wmmp_pkg::A_CLIP;
         end
         wmmp_pkg::A_CLIP: begin
            clip_hi_in = p >= OneQ27;
            clip_lo_in = p <= NegOneQ27;
            diff_in    = diff_full[wmmp_pkg::OneShift:0];
            state_in   = wmmp_pkg::A_MUL_H;
         end
         wmmp_pkg::A_MUL_H: begin
            mul_a    = signed'(wmmp_pkg::MulAW'(diff_ff));
            mul_b    = signed'(wmmp_pkg::MulBW'(h_eff));
            prod_en  = 1'b1;
            state_in = wmmp_pkg::A_MUL_K;
         end
         wmmp_pkg::A_MUL_K: begin
            row_in   = wmmp_pkg::CoordW'(arith_req.top) + wmmp_pkg::CoordW'(row_sel);
            mul_a    = signed'(wmmp_pkg::MulAW'(arith_req.k));
            mul_b    = signed'(wmmp_pkg::MulBW'(arith_req.width));
            prod_en  = 1'b1;
            state_in = wmmp_pkg::A_LOAD;
         end
         wmmp_pkg::A_LOAD: begin
            // k * width < count << QuoW, so the upper part starts below count
            rem_in   = prod_ff[wmmp_pkg::QuoW+wmmp_pkg::CountW-1:wmmp_pkg::QuoW];
            quo_in   = prod_ff[wmmp_pkg::QuoW-1:0];
            cnt_in   = wmmp_pkg::DivCntW'(wmmp_pkg::QuoW);
            state_in = wmmp_pkg::A_DIV;
         end
         wmmp_pkg::A_DIV: begin
            rem_in = div_ge ? div_sub[wmmp_pkg::CountW-1:0] : div_t[wmmp_pkg::CountW-1:0];
            quo_in = {quo_ff[wmmp_pkg::QuoW-2:0], div_ge};
            cnt_in = cnt_ff - wmmp_pkg::DivCntW'(1);
            if (cnt_ff == wmmp_pkg::DivCntW'(1)) begin
               state_in = wmmp_pkg::A_DONE;
            end
         end
         wmmp_pkg::A_DONE: begin
            done     = 1'b1;
            state_in = wmmp_pkg::A_IDLE;
         end
         default: begin
            state_in = wmmp_pkg::A_IDLE;
         end
      endcase

      prod_in = mul_a * mul_b;
   end

   assign arith_rsp.done = done;
   assign arith_rsp.row  = row_ff;
   assign arith_rsp.off  = quo_ff;

   a_rem_below_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wmmp_pkg::A_DIV) |-> (rem_ff < arith_req.count))
      else $error("divider remainder not below count");

endmodule

FILE: rtl/core/waveform_min_max_plotter_unit.sv
// Top level of the waveform min/max plotter: sequencer, column tracking, command output.
//
//  channel  | dir | handshake         | payload
//  req_chan | in  | valid/ready       | sample (Q15)
//  rsp_chan | out | valid/ready       | kind, x_start, y_start, x_end, y_end, rgb565, last
//  csr_*    | in  | csr_write_enable  | csr_index, csr_write_data
//
// A sample that draws nothing runs the arithmetic, a decide step and a finish step; a line
// adds a line step, and each column closed in span mode adds an overlap check, then a span.
// The arithmetic is mostly the 13-step restoring divider and three passes of the shared multiplier.
// With a plot width of zero a sample skips the arithmetic and goes straight to finish.
// Synchronous active-high reset; state clears at once, no clearing pass.
// Commands sit in an output register; a stalled rsp_chan holds the sequencer
// in its emit step, and req_chan.ready is low until the item is done.
module waveform_min_max_plotter_unit (
   input  logic                           clock,
   input  logic                           reset,
   wmmp_req_if.sink                       req_chan,
   wmmp_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [wmmp_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [wmmp_pkg::CsrDataW-1:0]  csr_write_data
);

   localparam int CW = wmmp_pkg::CoordW;

   // configuration
   logic [wmmp_pkg::COORD_BITS-1:0] left_ff, left_in;
   logic [wmmp_pkg::COORD_BITS-1:0] top_ff, top_in;
   logic [wmmp_pkg::ExtW-1:0]       width_ff, width_in;
   logic [wmmp_pkg::ExtW-1:0]       height_ff, height_in;
   logic [wmmp_pkg::ZoomW-1:0]      zoom_ff, zoom_in;
   logic [wmmp_pkg::CountW-1:0]     count_ff, count_in;
   logic [wmmp_pkg::ColorW-1:0]     color_ff, color_in;

   wmmp_pkg::top_state_type state_ff, state_in;

   logic [wmmp_pkg::CountW-1:0]       sample_index_ff, sample_index_in;
   logic [CW-1:0]                     cur_col_ff, cur_col_in;
   logic [CW-1:0]                     col_first_ff, col_first_in;
   logic [CW-1:0]                     col_last_ff, col_last_in;
   logic [CW-1:0]                     col_min_ff, col_min_in;
   logic [CW-1:0]                     col_max_ff, col_max_in;
   logic [CW-1:0]                     prev_min_ff, prev_min_in;
   logic [CW-1:0]                     prev_max_ff, prev_max_in;
   logic [CW-1:0]                     prev_last_ff, prev_last_in;
   logic                              have_prev_ff, have_prev_in;
   logic signed [wmmp_pkg::SampleW-1:0] sample_ff, sample_in;
   logic [wmmp_pkg::CountW-1:0]       k_ff, k_in;
   logic                              is_last_ff, is_last_in;
   logic                              final_ff, final_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_kind_ff, rsp_kind_in;
   logic [CW-1:0]                     rsp_xs_ff, rsp_xs_in;
   logic [CW-1:0]                     rsp_ys_ff, rsp_ys_in;
   logic [CW-1:0]                     rsp_xe_ff, rsp_xe_in;
   logic [CW-1:0]                     rsp_ye_ff, rsp_ye_in;
   logic [wmmp_pkg::RgbW-1:0]         rsp_rgb_ff, rsp_rgb_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              accept;
   logic                              slot_free;
   logic [wmmp_pkg::CountW-1:0]       count_eff;
   logic [wmmp_pkg::CountW-1:0]       acc_k;
   logic                              acc_last;
   logic                              line_mode;
   logic [CW-1:0]                     col;
   logic [CW-1:0]                     row;
   logic                              no_overlap;

   logic                              emit;
   logic                              emit_kind;
   logic [CW-1:0]                     emit_xs, emit_ys, emit_xe, emit_ye;
   logic                              emit_last;

   wmmp_pkg::arith_req_type           arith_req;
   wmmp_pkg::arith_rsp_type           arith_rsp;

   wmmp_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .arith_req (arith_req),
      .arith_rsp (arith_rsp)
   );

   assign req_chan.ready = !reset && (state_ff == wmmp_pkg::ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   assign count_eff = (count_ff == '0) ? wmmp_pkg::CountW'(1) : count_ff;
   assign acc_last  = sample_index_ff >= (count_eff - wmmp_pkg::CountW'(1));
   assign acc_k     = acc_last ? (count_eff - wmmp_pkg::CountW'(1)) : sample_index_ff;
   assign line_mode = (wmmp_pkg::CountW+1)'(count_eff) <
                      (wmmp_pkg::CountW+1)'({width_ff, 1'b0});

   assign col = CW'(left_ff) + CW'(arith_rsp.off);
   assign row = arith_rsp.row;
   assign no_overlap = have_prev_ff &&
                       ((col_max_ff < prev_min_ff) || (col_min_ff > prev_max_ff));

   assign arith_req.start  = accept && (width_ff != '0);
   assign arith_req.sample = sample_ff;
   assign arith_req.k      = k_ff;
   assign arith_req.zoom   = zoom_ff;
   assign arith_req.height = height_ff;
   assign arith_req.top    = top_ff;
   assign arith_req.width  = width_ff;
   assign arith_req.count  = count_eff;

   // configuration writes
   always_comb begin
      left_in   = left_ff;
      top_in    = top_ff;
      width_in  = width_ff;
      height_in = height_ff;
      zoom_in   = zoom_ff;
      count_in  = count_ff;
      color_in  = color_ff;
      if (csr_write_enable) begin
         unique case (wmmp_pkg::csr_index_type'(csr_index))
            wmmp_pkg::CSR_LEFT:   left_in   = csr_write_data[wmmp_pkg::COORD_BITS-1:0];
            wmmp_pkg::CSR_TOP:    top_in    = csr_write_data[wmmp_pkg::COORD_BITS-1:0];
            wmmp_pkg::CSR_WIDTH:  width_in  = csr_write_data[wmmp_pkg::ExtW-1:0];
            wmmp_pkg::CSR_HEIGHT: height_in = csr_write_data[wmmp_pkg::ExtW-1:0];
            wmmp_pkg::CSR_ZOOM:   zoom_in   = csr_write_data[wmmp_pkg::ZoomW-1:0];
            wmmp_pkg::CSR_COUNT:  count_in  = csr_write_data[wmmp_pkg::CountW-1:0];
            wmmp_pkg::CSR_COLOR:  color_in  = csr_write_data[wmmp_pkg::ColorW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      sample_index_in = sample_index_ff;
      cur_col_in      = cur_col_ff;
      col_first_in    = col_first_ff;
      col_last_in     = col_last_ff;
      col_min_in      = col_min_ff;
      col_max_in      = col_max_ff;
      prev_min_in     = prev_min_ff;
      prev_max_in     = prev_max_ff;
      prev_last_in    = prev_last_ff;
      have_prev_in    = have_prev_ff;
      sample_in       = sample_ff;
      k_in            = k_ff;
      is_last_in      = is_last_ff;
      final_in        = final_ff;

      emit      = 1'b0;
      emit_kind = wmmp_pkg::KIND_LINE;
      emit_xs   = cur_col_ff;
      emit_ys   = col_last_ff;
      emit_xe   = col;
      emit_ye   = row;
      emit_last = 1'b0;

      unique case (state_ff)
         wmmp_pkg::ST_IDLE: begin
            if (accept) begin
               sample_in  = req_chan.sample;
               k_in       = acc_k;
               is_last_in = acc_last;
               state_in   = (width_ff == '0) ? wmmp_pkg::ST_FINISH : wmmp_pkg::ST_ARITH;
            end
         end
         wmmp_pkg::ST_ARITH: begin
            if (arith_rsp.done) begin
               state_in = wmmp_pkg::ST_DECIDE;
            end
         end
         wmmp_pkg::ST_DECIDE: begin
            final_in = 1'b0;
            priority if (line_mode) begin
               if (k_ff != '0) begin
                  state_in = wmmp_pkg::ST_LINE;
               end else begin
                  cur_col_in   = col;
                  col_first_in = row;
                  col_last_in  = row;
                  col_min_in   = row;
                  col_max_in   = row;
                  state_in     = wmmp_pkg::ST_FINISH;
               end
            end else if ((k_ff == '0) || (col == cur_col_ff)) begin
               if (k_ff == '0) begin
                  cur_col_in   = col;
                  col_first_in = row;
                  col_last_in  = row;
                  col_min_in   = row;
                  col_max_in   = row;
               end else begin
                  if (row < col_min_ff) col_min_in = row;
                  if (row > col_max_ff) col_max_in = row;
                  col_last_in = row;
               end
               final_in = is_last_ff;
               state_in = is_last_ff ? wmmp_pkg::ST_JOIN : wmmp_pkg::ST_FINISH;
            end else begin
               state_in = wmmp_pkg::ST_JOIN;
            end
         end
         wmmp_pkg::ST_LINE: begin
            if (slot_free) begin
               emit         = 1'b1;
               emit_last    = is_last_ff;
               cur_col_in   = col;
               col_first_in = row;
               col_last_in  = row;
               col_min_in   = row;
               col_max_in   = row;
               state_in     = wmmp_pkg::ST_FINISH;
            end
         end
         wmmp_pkg::ST_JOIN: begin
            // joining line from the last row of the previous column
            if (!no_overlap) begin
               state_in = wmmp_pkg::ST_SPAN;
            end else if (slot_free) begin
               emit     = 1'b1;
               emit_xs  = cur_col_ff - CW'(1);
               emit_ys  = prev_last_ff;
               emit_xe  = cur_col_ff;
               emit_ye  = col_first_ff;
               state_in = wmmp_pkg::ST_SPAN;
            end
         end
         wmmp_pkg::ST_SPAN: begin
            if (slot_free) begin
               emit         = 1'b1;
               emit_kind    = wmmp_pkg::KIND_SPAN;
               emit_xs      = cur_col_ff;
               emit_ys      = col_min_ff;
               emit_xe      = cur_col_ff;
               emit_ye      = col_max_ff;
               emit_last    = final_ff;
               prev_min_in  = col_min_ff;
               prev_max_in  = col_max_ff;
               prev_last_in = col_last_ff;
               have_prev_in = 1'b1;
               if (final_ff) begin
                  state_in = wmmp_pkg::ST_FINISH;
               end else begin
                  cur_col_in   = col;
                  col_first_in = row;
                  col_last_in  = row;
                  col_min_in   = row;
                  col_max_in   = row;
                  final_in     = is_last_ff;
                  state_in     = is_last_ff ? wmmp_pkg::ST_JOIN : wmmp_pkg::ST_FINISH;
               end
            end
         end
         wmmp_pkg::ST_FINISH: begin
            if (is_last_ff) begin
               sample_index_in = '0;
               have_prev_in    = 1'b0;
            end else begin
               sample_index_in = k_ff + wmmp_pkg::CountW'(1);
            end
            state_in = wmmp_pkg::ST_IDLE;
         end
         default: begin
            state_in = wmmp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_xs_in    = rsp_xs_ff;
      rsp_ys_in    = rsp_ys_ff;
      rsp_xe_in    = rsp_xe_ff;
      rsp_ye_in    = rsp_ye_ff;
      rsp_rgb_in   = rsp_rgb_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_xs_in    = emit_xs;
         rsp_ys_in    = emit_ys;
         rsp_xe_in    = emit_xe;
         rsp_ye_in    = emit_ye;
         rsp_rgb_in   = wmmp_pkg::palette_lookup(color_ff);
         rsp_last_in  = emit_last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff         <= '0;
         top_ff          <= '0;
         width_ff        <= '0;
         height_ff       <= wmmp_pkg::ExtW'(1);
         zoom_ff         <= wmmp_pkg::ZoomW'(4096);
         count_ff        <= wmmp_pkg::CountW'(1);
         color_ff        <= '0;
         state_ff        <= wmmp_pkg::ST_IDLE;
         sample_index_ff <= '0;
         cur_col_ff      <= '0;
         col_first_ff    <= '0;
         col_last_ff     <= '0;
         col_min_ff      <= '0;
         col_max_ff      <= '0;
         prev_min_ff     <= '0;
         prev_max_ff     <= '0;
         prev_last_ff    <= '0;
         have_prev_ff    <= 1'b0;
         is_last_ff      <= 1'b0;
         final_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         left_ff         <= left_in;
         top_ff          <= top_in;
         width_ff        <= width_in;
         height_ff       <= height_in;
         zoom_ff         <= zoom_in;
         count_ff        <= count_in;
         color_ff        <= color_in;
         state_ff        <= state_in;
         sample_index_ff <= sample_index_in;
         cur_col_ff      <= cur_col_in;
         col_first_ff    <= col_first_in;
         col_last_ff     <= col_last_in;
         col_min_ff      <= col_min_in;
         col_max_ff      <= col_max_in;
         prev_min_ff     <= prev_min_in;
         prev_max_ff     <= prev_max_in;
         prev_last_ff    <= prev_last_in;
         have_prev_ff    <= have_prev_in;
         is_last_ff      <= is_last_in;
         final_ff        <= final_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      k_ff        <= k_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_xs_ff   <= rsp_xs_in;
      rsp_ys_ff   <= rsp_ys_in;
      rsp_xe_ff   <= rsp_xe_in;
      rsp_ye_ff   <= rsp_ye_in;
      rsp_rgb_ff  <= rsp_rgb_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.kind    = rsp_kind_ff;
   assign rsp_chan.x_start = rsp_xs_ff;
   assign rsp_chan.y_start = rsp_ys_ff;
   assign rsp_chan.x_end   = rsp_xe_ff;
   assign rsp_chan.y_end   = rsp_ye_ff;
   assign rsp_chan.rgb565  = rsp_rgb_ff;
   assign rsp_chan.last    = rsp_last_ff;

   a_arith_done_waited: assert property (@(posedge clock) disable iff (reset)
      arith_rsp.done |-> (state_ff == wmmp_pkg::ST_ARITH))
      else $error("arithmetic result arrived outside the wait step");

   a_column_ordered: assert property (@(posedge clock) disable iff (reset)
      col_min_ff <= col_max_ff)
      else $error("open column min row above max row");

   a_trace_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wmmp_pkg::ST_FINISH) && is_last_ff |=>
         (sample_index_ff == '0) && !have_prev_ff)
      else $error("trace end did not clear index and previous column");

   a_final_span_on_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wmmp_pkg::ST_SPAN) && final_ff |-> is_last_ff)
      else $error("final span outside the last item of a trace");

endmodule
